// ===== design/gsmf_pkg.sv =====
// package: codes, arithmetic constants and crc helper for the measure framer
`timescale 1ns / 1ps

package gsmf_pkg;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_HUMIDITY    = 1'b0,
    CFG_TEMPERATURE = 1'b1
  } gsmf_cfg_e;

  // input item function codes
  typedef enum logic [0:0] {
    FUNC_START = 1'b0,
    FUNC_RX    = 1'b1
  } gsmf_func_e;

  // result kind codes
  typedef enum logic [0:0] {
    KIND_TX     = 1'b0,
    KIND_RESULT = 1'b1
  } gsmf_kind_e;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;
  localparam int HUM_W      = 17;
  localparam int TEMP_W     = 18;
  localparam int FRAME_LEN  = 8;
  localparam int BEAT_CNT_W = 3;

  localparam logic [HUM_W-1:0]  HUM_RESET  = 17'd50000;
  localparam logic [TEMP_W-1:0] TEMP_RESET = 18'd25000;

  // fixed command header bytes
  localparam logic [7:0] CMD_HIGH = 8'h26;
  localparam logic [7:0] CMD_LOW  = 8'h0F;

  // crc-8, msb first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // divide by ten through a reciprocal, exact over the operand width
  localparam logic [15:0] HUM_DIV10_MUL   = 16'd52429;
  localparam int          HUM_DIV10_SHIFT = 19;
  localparam logic [17:0] TEMP_DIV10_MUL  = 18'd209716;
  localparam int          TEMP_DIV10_SHIFT = 21;

  // span divide: estimate low by at most one, fixed by one compare
  localparam logic [15:0] HUM_SPAN_MUL    = 16'd53687;
  localparam int          HUM_SPAN_SHIFT  = 29;
  localparam logic [13:0] HUM_SPAN        = 14'd10000;
  localparam logic [15:0] TEMP_SPAN_MUL   = 16'd61356;
  localparam int          TEMP_SPAN_SHIFT = 30;
  localparam logic [14:0] TEMP_SPAN       = 15'd17500;

  localparam logic signed [18:0] TEMP_OFFSET = 19'sd45000;
  localparam logic [15:0]        TICKS_MAX   = 16'hFFFF;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic        start;
    logic        res;
    logic [15:0] resistance;
    logic        crc_err;
  } gsmf_meta_t;

  // crc over two bytes, high byte first
  function automatic logic [7:0] crc8_two(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] crc;
    crc = CRC_INIT ^ hi;
    for (int b = 0; b < 8; b++) begin
      crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    crc = crc ^ lo;
    for (int b = 0; b < 8; b++) begin
      crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    return crc;
  endfunction

endpackage

// ===== design/gsmf_in_if.sv =====
// interface: input item channel
`timescale 1ns / 1ps

interface gsmf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// ===== design/gsmf_out_if.sv =====
// interface: result channel
`timescale 1ns / 1ps

interface gsmf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] resistance;
  logic        crc_error;

  modport source (output valid, output kind, output tx_byte, output last,
                  output resistance, output crc_error, input ready);
  modport sink (input valid, input kind, input tx_byte, input last,
                input resistance, input crc_error, output ready);
endinterface

// ===== design/gsmf_ticks.sv =====
// module: four-stage pipeline turning compensation values into sensor ticks
`timescale 1ns / 1ps

module gsmf_ticks (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [gsmf_pkg::HUM_W-1:0]       hum_i,
  input  logic signed [gsmf_pkg::TEMP_W-1:0] temp_i,
  output logic [15:0]                      hum_ticks_o,
  output logic [15:0]                      tc_ticks_o
);
  import gsmf_pkg::*;

  // stage 1: divide by ten
  logic signed [18:0] t_sum;
  logic [32:0]        h_prod1;
  logic [35:0]        t_prod1;
  logic [13:0]        h_q_d, h_q_q;
  logic [14:0]        t_q_d, t_q_q;

  assign t_sum   = 19'(temp_i) + TEMP_OFFSET;
  assign h_prod1 = 33'(hum_i) * 33'(HUM_DIV10_MUL);
  assign t_prod1 = 36'(t_sum[17:0]) * 36'(TEMP_DIV10_MUL);
  assign h_q_d   = h_prod1[HUM_DIV10_SHIFT +: 14];
  // negative sums end at or below zero and clamp to zero
  assign t_q_d   = t_sum[18] ? 15'd0 : t_prod1[TEMP_DIV10_SHIFT +: 15];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q_q <= h_q_d;
      t_q_q <= t_q_d;
    end
  end

  // stage 2: scale by 65535 and estimate the span quotient
  logic [29:0] h_x_d, h_x_q, h_x2_q;
  logic [30:0] t_x_d, t_x_q, t_x2_q;
  logic [45:0] h_prod2;
  logic [46:0] t_prod2;
  logic [16:0] h_est_q, h_est2_q, t_est_q, t_est2_q;

  assign h_x_d   = {h_q_q, 16'd0} - 30'(h_q_q);
  assign t_x_d   = {t_q_q, 16'd0} - 31'(t_q_q);
  assign h_prod2 = 46'(h_x_d) * 46'(HUM_SPAN_MUL);
  assign t_prod2 = 47'(t_x_d) * 47'(TEMP_SPAN_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_x_q   <= h_x_d;
      t_x_q   <= t_x_d;
      h_est_q <= h_prod2[HUM_SPAN_SHIFT +: 17];
      t_est_q <= t_prod2[TEMP_SPAN_SHIFT +: 17];
    end
  end

  // stage 3: back-multiply the estimate
  logic [30:0] h_prod3;
  logic [31:0] t_prod3;
  logic [29:0] h_p_q;
  logic [30:0] t_p_q;

  assign h_prod3 = 31'(h_est_q) * 31'(HUM_SPAN);
  assign t_prod3 = 32'(t_est_q) * 32'(TEMP_SPAN);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_p_q    <= h_prod3[29:0];
      t_p_q    <= t_prod3[30:0];
      h_x2_q   <= h_x_q;
      t_x2_q   <= t_x_q;
      h_est2_q <= h_est_q;
      t_est2_q <= t_est_q;
    end
  end

  // stage 4: remainder correction and clamp
  logic [29:0] h_rem;
  logic [30:0] t_rem;
  logic [17:0] h_fix, t_fix;

  assign h_rem = h_x2_q - h_p_q;
  assign t_rem = t_x2_q - t_p_q;
  assign h_fix = (h_rem >= 30'(HUM_SPAN)) ? 18'(h_est2_q) + 18'd1 : 18'(h_est2_q);
  assign t_fix = (t_rem >= 31'(TEMP_SPAN)) ? 18'(t_est2_q) + 18'd1 : 18'(t_est2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hum_ticks_o <= (h_fix > 18'(TICKS_MAX)) ? TICKS_MAX : h_fix[15:0];
      tc_ticks_o  <= (t_fix > 18'(TICKS_MAX)) ? TICKS_MAX : t_fix[15:0];
    end
  end

endmodule

// ===== design/gas_sensor_measure_framer.sv =====
// top level: measure command framer and response collector
`timescale 1ns / 1ps
//
// Usage:
// - item_i carries one item a beat: func start builds the eight-byte measure
//   command, func rx hands over one response byte.
// - result_o gives transmit beats (kind tx, last on the eighth byte) and, on
//   the third response byte after a start, one result beat with resistance
//   and crc_error. Response bytes with no start pending give no beat.
// - cfg_we_i / cfg_idx_i / cfg_wdata_i write humidity (index 0) and
//   temperature (index 1) compensation; write only while the block is idle.
// Path: an item reaches its first beat through the input register, four stages of
// the ticks pipeline and the output register. A start holds the output
// register for eight frame bytes, one byte a cycle while the receiver is
// ready; a response result holds it for one beat; an ignored byte none.
// The whole pipeline advances only while the output register is free or its
// last beat is taken, so the input keeps flowing during a frame's final beat.
// Reset: clears pipeline valids, pending flag, byte count and output state;
// compensation registers return to 50000 and 25000.
// Receiver stall: the current beat holds, the pipeline and input stall.

module gas_sensor_measure_framer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gsmf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gsmf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  gsmf_in_if.sink                           item_i,
  gsmf_out_if.source                        result_o
);
  import gsmf_pkg::*;

  // configuration registers
  logic [HUM_W-1:0]         hum_q;
  logic signed [TEMP_W-1:0] temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hum_q  <= HUM_RESET;
      temp_q <= TEMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HUMIDITY:    hum_q  <= cfg_wdata_i[HUM_W-1:0];
        CFG_TEMPERATURE: temp_q <= cfg_wdata_i[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: output free or its last beat leaving
  logic busy_q;
  logic kind_q;
  logic [BEAT_CNT_W-1:0] cnt_q;
  logic last_beat;
  logic emit_done;
  logic adv;

  assign last_beat = (kind_q == KIND_RESULT) || (cnt_q == BEAT_CNT_W'(FRAME_LEN - 1));
  assign emit_done = busy_q && result_o.ready && last_beat;
  assign adv       = !busy_q || emit_done;
  assign item_i.ready = adv;

  // input register
  logic       s0_valid_q;
  logic       s0_func_q;
  logic [7:0] s0_rx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_func_q <= item_i.func;
      s0_rx_q   <= item_i.rx_byte;
    end
  end

  // response collection state
  logic       pending_q, pending_d;
  logic [1:0] rx_count_q, rx_count_d;
  logic [7:0] rx_high_q, rx_low_q;
  gsmf_meta_t meta_d;

  always_comb begin
    pending_d  = pending_q;
    rx_count_d = rx_count_q;
    meta_d     = '0;
    meta_d.resistance = {rx_high_q, rx_low_q};
    meta_d.crc_err    = (crc8_two(rx_high_q, rx_low_q) != s0_rx_q);
    if (s0_valid_q) begin
      priority if (s0_func_q == FUNC_START) begin
        pending_d    = 1'b1;
        rx_count_d   = 2'd0;
        meta_d.start = 1'b1;
      end else if (pending_q) begin
        priority case (rx_count_q)
          2'd0: rx_count_d = 2'd1;
          2'd1: rx_count_d = 2'd2;
          default: begin
            meta_d.res = 1'b1;
            pending_d  = 1'b0;
            rx_count_d = 2'd0;
          end
        endcase
      end else begin
        // byte with nothing pending is dropped
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      rx_count_q <= 2'd0;
    end else if (adv) begin
      pending_q  <= pending_d;
      rx_count_q <= rx_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s0_valid_q && (s0_func_q == FUNC_RX) && pending_q) begin
      if (rx_count_q == 2'd0) rx_high_q <= s0_rx_q;
      if (rx_count_q == 2'd1) rx_low_q  <= s0_rx_q;
    end
  end

  // item control follows the ticks pipeline, four stages
  logic [3:0]       sv_q;
  gsmf_meta_t [3:0] sm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (adv) begin
      sv_q <= {sv_q[2:0], s0_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm_q <= {sm_q[2:0], meta_d};
    end
  end

  logic [15:0] hum_ticks, tc_ticks;

  gsmf_ticks u_ticks (
    .clk_i       (clk_i),
    .en_i        (adv),
    .hum_i       (hum_q),
    .temp_i      (temp_q),
    .hum_ticks_o (hum_ticks),
    .tc_ticks_o  (tc_ticks)
  );

  // frame assembly from final-stage ticks
  logic [FRAME_LEN-1:0][7:0] frame_d;
  logic s4_valid;
  gsmf_meta_t s4_meta;

  assign s4_valid = sv_q[3];
  assign s4_meta  = sm_q[3];

  always_comb begin
    frame_d[0] = CMD_HIGH;
    frame_d[1] = CMD_LOW;
    frame_d[2] = hum_ticks[15:8];
    frame_d[3] = hum_ticks[7:0];
    frame_d[4] = crc8_two(hum_ticks[15:8], hum_ticks[7:0]);
    frame_d[5] = tc_ticks[15:8];
    frame_d[6] = tc_ticks[7:0];
    frame_d[7] = crc8_two(tc_ticks[15:8], tc_ticks[7:0]);
  end

  // output register: frame shifter or single result beat
  logic [FRAME_LEN-1:0][7:0] frame_q;
  logic [15:0] res_q;
  logic        err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= KIND_TX;
      cnt_q  <= '0;
    end else if (adv) begin
      cnt_q <= '0;
      priority if (s4_valid && s4_meta.start) begin
        busy_q <= 1'b1;
        kind_q <= KIND_TX;
      end else if (s4_valid && s4_meta.res) begin
        busy_q <= 1'b1;
        kind_q <= KIND_RESULT;
      end else begin
        busy_q <= 1'b0;
        kind_q <= KIND_TX;
      end
    end else if (result_o.ready) begin
      cnt_q <= cnt_q + BEAT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s4_valid && s4_meta.start) frame_q <= frame_d;
      if (s4_valid && s4_meta.res) begin
        res_q <= s4_meta.resistance;
        err_q <= s4_meta.crc_err;
      end
    end else if (result_o.ready) begin
      frame_q <= {8'd0, frame_q[FRAME_LEN-1:1]};
    end
  end

  assign result_o.valid      = busy_q;
  assign result_o.kind       = kind_q;
  assign result_o.tx_byte    = (kind_q == KIND_RESULT) ? 8'd0 : frame_q[0];
  assign result_o.last       = last_beat;
  assign result_o.resistance = (kind_q == KIND_RESULT) ? res_q : 16'd0;
  assign result_o.crc_error  = (kind_q == KIND_RESULT) ? err_q : 1'b0;

  // checks on collection and output sequencing
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_count_q != 2'd3)
    else $error("byte count out of range");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q |-> rx_count_q == 2'd0)
    else $error("byte count moved with nothing pending");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && kind_q == KIND_RESULT) |-> cnt_q == '0)
    else $error("result beat counted as frame beat");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !result_o.ready) |=> busy_q && $stable(cnt_q) && $stable(kind_q))
    else $error("output moved under stall");

  a_frame_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s4_valid && s4_meta.start) |=> busy_q && cnt_q == '0 && kind_q == KIND_TX)
    else $error("frame not loaded from last stage");

endmodule

// ===== bench/tb.sv =====
// testbench: measure framer frames, response collection and crc flag checks
`timescale 1ns / 1ps

module tb;
  import gsmf_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 24;
  localparam int CHUNK_ITEMS  = 20;

  typedef struct packed {
    gsmf_kind_e  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] resistance;
    logic        crc_error;
  } beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gsmf_in_if  item_if ();
  gsmf_out_if res_if ();

  gas_sensor_measure_framer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (res_if)
  );

  // mirror of the block state and compensation registers
  logic [HUM_W-1:0]  hum_reg  = HUM_RESET;
  logic [TEMP_W-1:0] temp_reg = TEMP_RESET;
  logic              armed    = 1'b0;
  logic [1:0]        rx_seen  = 2'd0;
  logic [7:0]        rx_hi;
  logic [7:0]        rx_lo;

  beat_t       due_beats[$];
  int unsigned fail_count  = 0;
  int unsigned used_items  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // crc-8 poly 0x31, bit-serial, msb first
  function automatic logic [7:0] crc8_pair(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] data;
    logic [7:0]  c;
    logic        fb;
    data = {a, b};
    c = CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [15:0] clamp_ticks(input longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [15:0] humidity_ticks(input logic [HUM_W-1:0] h);
    longint v;
    v = h;
    return clamp_ticks((v / 10) * 65535 / 10000);
  endfunction

  function automatic logic [15:0] temperature_ticks(input logic [TEMP_W-1:0] t);
    logic signed [TEMP_W-1:0] ts;
    longint v;
    ts = t;
    v = ts;
    v = v + 45000;
    return clamp_ticks((v / 10) * 65535 / 17500);
  endfunction

  // work out the beats one accepted item causes
  task automatic framer_step(input gsmf_func_e f, input logic [7:0] b);
    logic [15:0] ht;
    logic [15:0] tt;
    logic [7:0]  frame [FRAME_LEN];
    beat_t       bt;
    if (f == FUNC_START) begin
      ht = humidity_ticks(hum_reg);
      tt = temperature_ticks(temp_reg);
      frame[0] = CMD_HIGH;
      frame[1] = CMD_LOW;
      frame[2] = ht[15:8];
      frame[3] = ht[7:0];
      frame[4] = crc8_pair(ht[15:8], ht[7:0]);
      frame[5] = tt[15:8];
      frame[6] = tt[7:0];
      frame[7] = crc8_pair(tt[15:8], tt[7:0]);
      for (int k = 0; k < FRAME_LEN; k++) begin
        bt.kind       = KIND_TX;
        bt.tx_byte    = frame[k];
        bt.last       = (k == FRAME_LEN - 1);
        bt.resistance = 16'h0000;
        bt.crc_error  = 1'b0;
        due_beats.push_back(bt);
      end
      armed   = 1'b1;
      rx_seen = 2'd0;
      used_items++;
    end else if (armed) begin
      used_items++;
      case (rx_seen)
        2'd0: begin
          rx_hi   = b;
          rx_seen = 2'd1;
        end
        2'd1: begin
          rx_lo   = b;
          rx_seen = 2'd2;
        end
        default: begin
          bt.kind       = KIND_RESULT;
          bt.tx_byte    = 8'h00;
          bt.last       = 1'b1;
          bt.resistance = {rx_hi, rx_lo};
          bt.crc_error  = (crc8_pair(rx_hi, rx_lo) != b);
          due_beats.push_back(bt);
          armed   = 1'b0;
          rx_seen = 2'd0;
        end
      endcase
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // compare each taken beat with the oldest one due
  always @(posedge clk_i) begin : beat_check
    beat_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got kind %0h tx %0h res %0h",
                 $time, res_if.kind, res_if.tx_byte, res_if.resistance);
        fail_count++;
      end else begin
        want = due_beats.pop_front();
        check_field("kind", want.kind, res_if.kind);
        check_field("tx_byte", want.tx_byte, res_if.tx_byte);
        check_field("last", want.last, res_if.last);
        check_field("resistance", want.resistance, res_if.resistance);
        check_field("crc_error", want.crc_error, res_if.crc_error);
      end
    end
  end

  // one input beat, with random sender gaps ahead of it
  task automatic send_item(input gsmf_func_e f, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.func    <= f;
    item_if.rx_byte <= b;
    @(posedge clk_i);
    while (item_if.ready !== 1'b1) @(posedge clk_i);
    framer_step(f, b);
  endtask

  task automatic wait_for_results();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_beats.size() != 0) @(posedge clk_i);
  endtask

  // write both compensation registers while the block is quiet
  task automatic load_compensation(input logic [CFG_DATA_W-1:0] hum_val,
                                   input logic [CFG_DATA_W-1:0] temp_val);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HUMIDITY;
    cfg_wdata_i <= hum_val;
    @(posedge clk_i);
    hum_reg = hum_val[HUM_W-1:0];
    cfg_idx_i   <= CFG_TEMPERATURE;
    cfg_wdata_i <= temp_val;
    @(posedge clk_i);
    temp_reg = temp_val;
    cfg_we_i <= 1'b0;
  endtask

  // start, two data bytes, then crc byte (good unless corrupted)
  task automatic measure_cycle(input logic [7:0] hi, input logic [7:0] lo,
                               input logic [7:0] crc_flip);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_RX, hi);
    send_item(FUNC_RX, lo);
    send_item(FUNC_RX, crc8_pair(hi, lo) ^ crc_flip);
  endtask

  task automatic test_stray_bytes();
    send_item(FUNC_RX, 8'h00);
    send_item(FUNC_RX, 8'hFF);
  endtask

  task automatic test_reset_frame();
    measure_cycle(8'h00, 8'hFF, 8'h00);
  endtask

  task automatic test_crc_mismatch();
    measure_cycle(8'hFF, 8'h00, 8'hFF);
  endtask

  // a second start abandons the half-collected response
  task automatic test_restart();
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_RX, 8'hA5);
    send_item(FUNC_START, 8'hFF);
    send_item(FUNC_RX, 8'h5A);
    send_item(FUNC_RX, 8'hC3);
    send_item(FUNC_RX, crc8_pair(8'h5A, 8'hC3));
  endtask

  // range ends and out-of-range values that saturate the ticks
  task automatic test_compensation_corners();
    logic [CFG_DATA_W-1:0] hum_set  [6];
    logic [CFG_DATA_W-1:0] temp_set [6];
    hum_set  = '{18'd0, 18'd100000, 18'h3FFFF, 18'd50000, 18'd1, 18'd99999};
    temp_set = '{18'(-45000), 18'd130000, 18'h1FFFF, 18'h20000, 18'(-45009),
                 18'd129999};
    for (int i = 0; i < 6; i++) begin
      load_compensation(hum_set[i], temp_set[i]);
      send_item(FUNC_START, 8'h00);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_humidity();
    case ($urandom_range(0, 3))
      0: return 18'($urandom_range(0, 100000));
      1: return 18'($urandom);
      2: return 18'd100000;
      default: return 18'd0;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_temperature();
    case ($urandom_range(0, 3))
      0: return 18'($urandom_range(0, 175000) - 45000);
      1: return 18'($urandom);
      2: return 18'd130000;
      default: return 18'(-45000);
    endcase
  endfunction

  // mostly complete measurements, some abandoned, some stray or random beats
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned pick;
    int unsigned goal;
    logic [7:0]  flip;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 2; chunk++) begin
      load_compensation(random_humidity(), random_temperature());
      goal = used_items + CHUNK_ITEMS;
      while (used_items < goal) begin
        if (used_items == goal - CHUNK_ITEMS / 2) wait_for_results();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          flip = ($urandom_range(0, 4) == 0) ? (8'h01 << $urandom_range(0, 7)) : 8'h00;
          measure_cycle(8'($urandom), 8'($urandom), flip);
        end else if (pick < 80) begin
          send_item(FUNC_START, 8'($urandom));
          repeat ($urandom_range(0, 2)) send_item(FUNC_RX, 8'($urandom));
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 3)) send_item(FUNC_RX, 8'($urandom));
        end else begin
          send_item(gsmf_func_e'($urandom_range(0, 1)), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_HUMIDITY;
    cfg_wdata_i     <= '0;
    item_if.valid   <= 1'b0;
    item_if.func    <= FUNC_START;
    item_if.rx_byte <= 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 78;
    test_stray_bytes();
    test_reset_frame();
    test_crc_mismatch();
    test_restart();
    test_compensation_corners();

    test_random_traffic(37, 78);
    test_random_traffic(78, 37);
    test_random_traffic(0, 0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gsmf_pkg.sv
design/gsmf_in_if.sv
design/gsmf_out_if.sv
design/gsmf_ticks.sv
design/gas_sensor_measure_framer.sv
bench/tb.sv
